/* hw/rtl/lssp_pkg.sv */
// lssp_pkg: shared types, constants and functions of the led strip symbol packer
// no dependencies

package lssp_pkg;

  localparam int COLOR_BITS  = 24;
  localparam int SYM_LEN     = 3;
  localparam int SYM_BITS    = COLOR_BITS * SYM_LEN;
  localparam int SHIFT_W     = 7;
  localparam int BRIGHT_W    = 9;
  localparam int CHAN_W      = 8;
  localparam int OUT_W       = 32;

  localparam logic [SYM_LEN-1:0]  SYM_ONE        = 3'b110;
  localparam logic [SYM_LEN-1:0]  SYM_ZERO       = 3'b100;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET   = 9'd256;
  localparam logic [CHAN_W-1:0]   CHAN_MAX       = 8'hff;

  // one pixel worth of symbol bits, earliest bit at the top
  typedef struct packed {
    logic [SYM_BITS-1:0] sym;
    logic                frame_end;
  } entry_t;

  // expand each color bit into its 3-bit symbol, msb first
  function automatic logic [SYM_BITS-1:0] expand(input logic [COLOR_BITS-1:0] color);
    logic [SYM_BITS-1:0] s;
    s = '0;
    for (int i = 0; i < COLOR_BITS; i++) begin
      s[i*SYM_LEN +: SYM_LEN] = color[i] ? SYM_ONE : SYM_ZERO;
    end
    return s;
  endfunction

endpackage

/* hw/rtl/lssp_pixel_if.sv */
// lssp_pixel_if: pixel channel, valid/ready with rgb and frame end
// no dependencies

interface lssp_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_end;

  modport source (output valid, red, green, blue, frame_end, input ready);
  modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

/* hw/rtl/lssp_word_if.sv */
// lssp_word_if: output word channel, valid/ready with packed symbols
// no dependencies

interface lssp_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        word_last;

  modport source (output valid, out_word, word_last, input ready);
  modport sink   (input valid, out_word, word_last, output ready);
endinterface

/* hw/rtl/lssp_cfg_if.sv */
// lssp_cfg_if: brightness register write channel
// no dependencies

interface lssp_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/led_strip_symbol_packer.sv */
// led_strip_symbol_packer: top level, brightness register, front, queue, back
// depends on lssp_pkg, lssp_pixel_if, lssp_word_if, lssp_cfg_if, lssp_front,
// lssp_queue and lssp_back
// a pixel passes the front register, a queue slot and the back symbol register
//   before its words go into the output register
// throughput: one word per cycle from the packer while the sink is ready, apart
//   from steps that only fold a pixel's leftover bits into the carry
// reset: synchronous active-high rst clears carry, queue and valids, brightness 256

module led_strip_symbol_packer #(
  parameter int WORD_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  lssp_pixel_if.sink   pixel,
  lssp_word_if.source  symbols,
  lssp_cfg_if.sink     cfg
);

  // brightness register, always writable
  logic [lssp_pkg::BRIGHT_W-1:0] brightness;

  // front to queue
  logic             push_valid;
  logic             push_ready;
  lssp_pkg::entry_t push_data;

  // queue to back
  logic             pop_valid;
  logic             pop_ready;
  lssp_pkg::entry_t pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= lssp_pkg::BRIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      brightness <= cfg.data;
    end
  end

  // front: takes a pixel, scales and expands it into 72 symbol bits
  lssp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .brightness (brightness),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // short queue decouples pixel intake from word output stalls
  lssp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  // back: slices symbol bits into words, carries leftovers, flushes at frame end
  lssp_back #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .words     (symbols)
  );

endmodule

/* hw/rtl/lssp_front.sv */
// lssp_front: pixel input stage, brightness scaling and symbol expansion
// depends on lssp_pkg and lssp_pixel_if

module lssp_front (
  input  logic                            clk,
  input  logic                            rst,
  lssp_pixel_if.sink                      pixel,
  input  logic [lssp_pkg::BRIGHT_W-1:0]   brightness,
  output logic                            push_valid,
  input  logic                            push_ready,
  output lssp_pkg::entry_t                push_data
);

  logic                          st_valid;
  logic [lssp_pkg::CHAN_W-1:0]   red;
  logic [lssp_pkg::CHAN_W-1:0]   green;
  logic [lssp_pkg::CHAN_W-1:0]   blue;
  logic                          frame_end;
  logic [lssp_pkg::CHAN_W-1:0]   red_s;
  logic [lssp_pkg::CHAN_W-1:0]   green_s;
  logic [lssp_pkg::CHAN_W-1:0]   blue_s;

  function automatic logic [lssp_pkg::CHAN_W-1:0] scale(
    input logic [lssp_pkg::CHAN_W-1:0]   c,
    input logic [lssp_pkg::BRIGHT_W-1:0] b
  );
    logic [16:0] prod;
    logic [8:0]  v;
    prod = {9'd0, c} * {8'd0, b};
    v    = prod[16:8];
    return v[8] ? lssp_pkg::CHAN_MAX : v[7:0];
  endfunction

  assign pixel.ready = !st_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (pixel.ready) begin
      st_valid <= pixel.valid;
    end
    if (pixel.valid && pixel.ready) begin
      red       <= pixel.red;
      green     <= pixel.green;
      blue      <= pixel.blue;
      frame_end <= pixel.frame_end;
    end
  end

  always_comb begin
    red_s   = scale(red, brightness);
    green_s = scale(green, brightness);
    blue_s  = scale(blue, brightness);
    push_data.sym       = lssp_pkg::expand({green_s, red_s, blue_s});
    push_data.frame_end = frame_end;
  end

  assign push_valid = st_valid;

endmodule

/* hw/rtl/lssp_queue.sv */
// lssp_queue: two-entry queue of expanded pixels between front and back
// depends on lssp_pkg

module lssp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lssp_pkg::entry_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lssp_pkg::entry_t  out_data
);

  lssp_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slots[wr_ptr] <= in_data;
  end

endmodule

/* hw/rtl/lssp_back.sv */
// lssp_back: packs symbol bits into words with carry, flush and output register
// depends on lssp_pkg and lssp_word_if

module lssp_back #(
  parameter int WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  lssp_pkg::entry_t  pop_data,
  lssp_word_if.source       words
);

  localparam int CW = $clog2(WORD_WIDTH);
  localparam logic [lssp_pkg::SHIFT_W-1:0] WordW7 = lssp_pkg::SHIFT_W'(WORD_WIDTH);
  localparam logic [lssp_pkg::SHIFT_W-1:0] SymW7  = lssp_pkg::SHIFT_W'(lssp_pkg::SYM_BITS);

  logic                              cur_valid;
  logic [lssp_pkg::SYM_BITS-1:0]     sym;
  logic [lssp_pkg::SHIFT_W-1:0]      rem;
  logic                              frame_end;
  logic [WORD_WIDTH-2:0]             carry;
  logic [CW-1:0]                     cnt;
  logic                              o_valid;
  logic [WORD_WIDTH-1:0]             o_word;
  logic                              o_last;

  logic [lssp_pkg::SHIFT_W-1:0]      avail;
  logic [lssp_pkg::SHIFT_W-1:0]      take;
  logic                              full;
  logic [lssp_pkg::SYM_BITS-1:0]     sym_hi;
  logic [WORD_WIDTH-1:0]             merged;
  logic                              need_out;
  logic                              out_free;
  logic                              step;
  logic                              done;
  logic                              emit;
  logic [WORD_WIDTH-1:0]             emit_word;
  logic                              emit_last;
  logic [WORD_WIDTH+31:0]            word_ext;

  always_comb begin
    avail    = WordW7 - lssp_pkg::SHIFT_W'(cnt);
    full     = (rem >= avail);
    take     = full ? avail : rem;
    sym_hi   = sym >> (SymW7 - take);
    merged   = ({1'b0, carry} << take) | sym_hi[WORD_WIDTH-1:0];
    need_out = full || frame_end;
    out_free = !o_valid || words.ready;
    step     = cur_valid && (!need_out || out_free);
    done     = step && (!full || (rem == avail));
    emit     = step && need_out;
    if (full) begin
      emit_word = merged;
      emit_last = frame_end && (rem == avail);
    end else begin
      // flush: pad the partial word with zeros in its low bits
      emit_word = merged << (avail - rem);
      emit_last = 1'b1;
    end
    pop_ready = !cur_valid || done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      carry     <= '0;
      cnt       <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (step) begin
        if (full || frame_end) begin
          carry <= '0;
          cnt   <= '0;
        end else begin
          carry <= merged[WORD_WIDTH-2:0];
          cnt   <= cnt + CW'(rem);
        end
      end
      if (pop_ready) begin
        cur_valid <= pop_valid;
      end
      if (emit) begin
        o_valid <= 1'b1;
      end else if (words.ready) begin
        o_valid <= 1'b0;
      end
    end
    if (pop_ready && pop_valid) begin
      sym       <= pop_data.sym;
      rem       <= SymW7;
      frame_end <= pop_data.frame_end;
    end else if (step && full) begin
      sym <= sym << take;
      rem <= rem - take;
    end
    if (emit) begin
      o_word <= emit_word;
      o_last <= emit_last;
    end
  end

  assign word_ext        = {32'd0, o_word};
  assign words.valid     = o_valid;
  assign words.out_word  = word_ext[lssp_pkg::OUT_W-1:0];
  assign words.word_last = o_last;

endmodule

/* test/tb.sv */
// tb: self-checking bench for led_strip_symbol_packer, random pixels against a local packer model
// depends on lssp_pkg, lssp_pixel_if, lssp_word_if, lssp_cfg_if and the packer rtl

`timescale 1ns / 1ps

module tb;

  localparam int WORD_W     = 32;
  localparam int RESET_CYC  = 12;
  localparam int SETTLE_CYC = 8;     // quiet cycles before a brightness write
  localparam int DRAIN_CYC  = 20;    // extra cycles at the end to catch stray words
  localparam int STALL_MAX  = 2000;  // watchdog limit, cycles with no handshake
  localparam int PHASE_LEN  = 10;

  typedef struct {
    logic [lssp_pkg::CHAN_W-1:0] red;
    logic [lssp_pkg::CHAN_W-1:0] green;
    logic [lssp_pkg::CHAN_W-1:0] blue;
    logic                        frame_end;
  } pixel_t;

  typedef struct {
    logic [lssp_pkg::OUT_W-1:0] out_word;
    logic                       word_last;
  } sym_word_t;

  logic clk;
  logic rst;

  lssp_pixel_if pix_bus ();
  lssp_word_if  word_bus ();
  lssp_cfg_if   cfg_bus ();

  led_strip_symbol_packer #(
    .WORD_WIDTH(WORD_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_bus),
    .symbols(word_bus),
    .cfg    (cfg_bus)
  );

  // stimulus and expectation stores
  pixel_t    pixel_queue[$];
  sym_word_t words_due[$];

  // model state: brightness copy and the symbol bits waiting for a full word
  logic [lssp_pkg::BRIGHT_W-1:0] model_bright;
  logic [WORD_W-1:0]             carry_bits;
  int                            carry_cnt;

  int pixels_queued;
  int pixels_taken;
  int errors;
  int pix_gap;
  int rdy_stall;
  int quiet_cycles;
  bit calm;            // no idling on either side in the closing phase

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("%0t: %s", $realtime, msg);
    errors++;
  endtask

  // scale one channel, truncate, saturate at full intensity
  function automatic logic [lssp_pkg::CHAN_W-1:0] scale_chan(
    input logic [lssp_pkg::CHAN_W-1:0]   c,
    input logic [lssp_pkg::BRIGHT_W-1:0] br
  );
    logic [lssp_pkg::CHAN_W+lssp_pkg::BRIGHT_W-1:0] prod;
    logic [lssp_pkg::BRIGHT_W-1:0]                  v;
    prod = c * br;
    v    = prod[lssp_pkg::CHAN_W+lssp_pkg::BRIGHT_W-1:8];
    return (v > lssp_pkg::CHAN_MAX) ? lssp_pkg::CHAN_MAX : v[lssp_pkg::CHAN_W-1:0];
  endfunction

  // expand one pixel into symbol bits and push every completed word onto words_due
  task automatic pack_pixel(input pixel_t p);
    logic [lssp_pkg::COLOR_BITS-1:0] color;
    logic [lssp_pkg::SYM_LEN-1:0]    sym;
    int                              made;
    made  = 0;
    color = {scale_chan(p.green, model_bright), scale_chan(p.red, model_bright),
             scale_chan(p.blue, model_bright)};
    for (int i = lssp_pkg::COLOR_BITS - 1; i >= 0; i--) begin
      sym = color[i] ? lssp_pkg::SYM_ONE : lssp_pkg::SYM_ZERO;
      for (int k = lssp_pkg::SYM_LEN - 1; k >= 0; k--) begin
        carry_bits = {carry_bits[WORD_W-2:0], sym[k]};
        carry_cnt++;
        if (carry_cnt == WORD_W) begin
          words_due.push_back('{out_word: carry_bits, word_last: 1'b0});
          made++;
          carry_bits = '0;
          carry_cnt  = 0;
        end
      end
    end
    if (p.frame_end) begin
      // partial word goes out left aligned with zero fill
      if (carry_cnt > 0) begin
        words_due.push_back('{out_word: carry_bits << (WORD_W - carry_cnt),
                              word_last: 1'b0});
        made++;
        carry_bits = '0;
        carry_cnt  = 0;
      end
      // the pixel's final word closes the frame, padded or not
      if (made > 0)
        words_due[$].word_last = 1'b1;
    end
  endtask

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic fe);
    pixel_queue.push_back('{red: r, green: g, blue: b, frame_end: fe});
    pixels_queued++;
  endtask

  // channel values lean on the extremes now and then
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly proper frames ending in frame_end, an occasional frame with random end flags
  task automatic add_frames(input int n);
    int len;
    bit broken;
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      len    = $urandom_range(1, 6);
      broken = ($urandom_range(0, 7) == 0);
      for (int j = 0; j < len; j++)
        add_pixel(rand_chan(), rand_chan(), rand_chan(),
                  broken ? 1'($urandom_range(0, 1)) : (j == len - 1));
      cnt += len;
    end
  endtask

  // block until every queued pixel is taken and every expected word has come out
  task automatic wait_drained();
    do @(posedge clk);
    while (pixels_taken != pixels_queued || words_due.size() != 0);
  endtask

  task automatic write_brightness(input logic [lssp_pkg::BRIGHT_W-1:0] val);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= val;
    do @(posedge clk);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // pixel driver: next pixel from the queue, random gaps between pixels
  always @(posedge clk) begin
    if (rst) begin
      pix_bus.valid <= 1'b0;
      pix_gap = 0;
    end else if (!pix_bus.valid || pix_bus.ready) begin
      if (pix_gap > 0) begin
        pix_gap--;
        pix_bus.valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        pix_bus.valid     <= 1'b1;
        pix_bus.red       <= pixel_queue[0].red;
        pix_bus.green     <= pixel_queue[0].green;
        pix_bus.blue      <= pixel_queue[0].blue;
        pix_bus.frame_end <= pixel_queue[0].frame_end;
        void'(pixel_queue.pop_front());
        if (!calm && $urandom_range(0, 4) == 0)
          pix_gap = $urandom_range(1, 10);
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  // word sink: ready drops for random bursts
  always @(posedge clk) begin
    if (rst) begin
      word_bus.ready <= 1'b0;
      rdy_stall = 0;
    end else if (rdy_stall > 0) begin
      rdy_stall--;
      word_bus.ready <= 1'b0;
    end else begin
      word_bus.ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0)
        rdy_stall = $urandom_range(1, 10);
    end
  end

  // monitor: track brightness writes, predict taken pixels, check words that leave
  always @(posedge clk) begin
    sym_word_t want;
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready)
        model_bright = cfg_bus.data;
      if (pix_bus.valid && pix_bus.ready) begin
        pack_pixel('{red: pix_bus.red, green: pix_bus.green, blue: pix_bus.blue,
                     frame_end: pix_bus.frame_end});
        pixels_taken++;
      end
      if (word_bus.valid && word_bus.ready) begin
        if (words_due.size() == 0) begin
          report($sformatf("unexpected word %h last %b", word_bus.out_word,
                           word_bus.word_last));
        end else begin
          want = words_due.pop_front();
          if (word_bus.out_word !== want.out_word)
            report($sformatf("out_word got %h want %h", word_bus.out_word, want.out_word));
          if (word_bus.word_last !== want.word_last)
            report($sformatf("word_last got %b want %b", word_bus.word_last,
                             want.word_last));
        end
      end
    end
  end

  // watchdog: any handshake resets the count
  always @(posedge clk) begin
    if (rst || (pix_bus.valid && pix_bus.ready) || (word_bus.valid && word_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [lssp_pkg::BRIGHT_W-1:0] levels[$];
    clk               = 1'b0;
    rst               = 1'b1;
    pix_bus.valid     = 1'b0;
    pix_bus.red       = '0;
    pix_bus.green     = '0;
    pix_bus.blue      = '0;
    pix_bus.frame_end = 1'b0;
    word_bus.ready    = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.data      = '0;
    model_bright      = lssp_pkg::BRIGHT_RESET;
    carry_bits        = '0;
    carry_cnt         = 0;
    pixels_queued     = 0;
    pixels_taken      = 0;
    errors            = 0;
    quiet_cycles      = 0;
    calm              = 1'b0;

    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;

    // directed part at full scale, carry walks 8, 16, 24, 0 bits between pixels
    write_brightness(lssp_pkg::BRIGHT_RESET);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b1);  // flush of a 16-bit tail
    add_pixel(8'haa, 8'h55, 8'hf0, 1'b0);
    add_pixel(8'hff, 8'h00, 8'h00, 1'b0);
    add_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    add_pixel(8'h00, 8'h00, 8'hff, 1'b1);  // frame ends on a word boundary, no pad word
    add_pixel(8'h80, 8'h01, 8'h7f, 1'b1);  // single-pixel frame, 8-bit tail
    add_pixel(8'h01, 8'h80, 8'hfe, 1'b0);
    add_pixel(8'h55, 8'haa, 8'h0f, 1'b1);
    add_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    add_pixel(8'h78, 8'h9a, 8'hbc, 1'b0);
    add_pixel(8'hde, 8'hf0, 8'h0e, 1'b0);
    add_pixel(8'h7f, 8'hfe, 8'h81, 1'b1);  // boundary end after three carries
    add_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    add_pixel(8'hc3, 8'h3c, 8'h99, 1'b0);
    wait_drained();

    // extremes of brightness first: off, max overdrive, minimum, near full, just above full
    levels = '{9'd0, 9'd511, 9'd1, 9'd255, 9'd257, 9'd128};
    levels.push_back(9'($urandom_range(257, 511)));
    levels.push_back(9'($urandom_range(0, 511)));
    foreach (levels[i]) begin
      write_brightness(levels[i]);
      // overdrive with bright channels shows saturation early in the phase
      if (levels[i] > lssp_pkg::BRIGHT_RESET)
        add_pixel(8'hff, 8'h80, 8'h01, 1'b1);
      add_frames(PHASE_LEN);
      wait_drained();
    end

    // closing phase at full scale, both sides run without gaps
    write_brightness(lssp_pkg::BRIGHT_RESET);
    calm = 1'b1;
    add_frames(PHASE_LEN);
    add_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b1);
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);

    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
